// ----- rtl/lerast_pkg.sv -----
package lerast_pkg;

    localparam int COORD_BITS = 6;
    localparam int IN_DATA_BITS = 4 * COORD_BITS;
    localparam int IN_TDATA_BITS = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 2 * COORD_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] t_coord;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch a new pair of endpoints
        logic step;   // produce the next pixel into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;  // line has no interior pixel
        logic last;   // current step is the final one
    } t_status;

endpackage

// ----- rtl/line_equation_rasterizer.sv -----
// Line rasterizer: one transaction on the slave side carries two endpoints;
// the master side returns the interior pixels of that line, endpoints
// excluded, in order from the endpoint with the smaller x (the start one on a tie),
// with tlast on the final pixel. A line with coinciding or adjacent endpoints
// returns nothing. Throughput: one pixel per cycle along the major axis while
// the receiver takes them, for a line of n = max(|dx|,|dy|) - 1 pixels (at
// most 62). The rate is set by the single minor-axis accumulator, which
// steps once per pixel.
// s_axis_tready is high only while no line is in progress; the last pixel may
// still sit in the output register while the next line is accepted.
// When the receiver stalls, the output register holds its pixel and the
// stepping pauses. Reset (synchronous, active low) drops any line in
// progress and clears the output valid.
module line_equation_rasterizer
    import lerast_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // pixel_x, pixel_y, zero pad
    output logic                      m_axis_tlast    // last_pixel
);

    t_cmd    cmd;
    t_status sts;
    t_coord  pixel_x, pixel_y;

    lerast_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    lerast_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_start_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_start_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_end_x      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_end_y      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_sts        (sts),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_last_pixel (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'({pixel_y, pixel_x});

endmodule

// ----- rtl/lerast_ctrl.sv -----
module lerast_ctrl
    import lerast_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        o_cmd.load = s_axis_tvalid && (r_state == ST_IDLE);
        o_cmd.step = (r_state == ST_RUN) && !i_sts.empty && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_sts.empty || (o_cmd.step && i_sts.last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN))
        else $error("load did not start a line");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.last) |=> (r_state == ST_IDLE))
        else $error("line did not end after last pixel");

    a_empty_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && i_sts.empty) |=> (r_state == ST_IDLE && !m_axis_tvalid
            || r_state == ST_IDLE && $past(r_out_valid)))
        else $error("empty line produced a pixel");

    a_step_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> r_out_valid)
        else $error("stepped pixel not presented");

endmodule

// ----- rtl/lerast_dp.sv -----
module lerast_dp
    import lerast_pkg::*;
(
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    input  t_coord  i_start_x,
    input  t_coord  i_start_y,
    input  t_coord  i_end_x,
    input  t_coord  i_end_y,
    output t_status o_sts,
    output t_coord  o_pixel_x,
    output t_coord  o_pixel_y,
    output logic    o_last_pixel
);

    t_coord r_x0, r_y0, r_dmaj, r_dmin, r_step, r_quo, r_rem;
    logic   r_fall, r_xmaj;
    t_coord r_px, r_py;
    logic   r_last;

    // endpoint ordering for a new line
    logic   swap, fall, xmaj;
    t_coord x0, y0, x1, y1, dx, dy;

    always_comb begin
        swap = (i_end_x < i_start_x);
        x0   = swap ? i_end_x   : i_start_x;
        y0   = swap ? i_end_y   : i_start_y;
        x1   = swap ? i_start_x : i_end_x;
        y1   = swap ? i_start_y : i_end_y;
        fall = (y1 < y0);
        dx   = x1 - x0;
        dy   = fall ? (y0 - y1) : (y1 - y0);
        xmaj = (dy < dx);
    end

    // one step of the minor fraction dmin*s/dmaj; dmin <= dmaj keeps rem below 2*dmaj
    logic [COORD_BITS:0] rem_sum;
    logic                wrap;
    t_coord              quo_nxt, rem_nxt, minor_ceil, px, py;

    always_comb begin
        rem_sum = {1'b0, r_rem} + {1'b0, r_dmin};
        wrap    = (rem_sum >= {1'b0, r_dmaj});
        quo_nxt = wrap ? (r_quo + t_coord'(1)) : r_quo;
        rem_nxt = wrap ? COORD_BITS'(rem_sum - {1'b0, r_dmaj}) : rem_sum[COORD_BITS-1:0];
        minor_ceil = quo_nxt + ((rem_nxt != '0) ? t_coord'(1) : t_coord'(0));
        if (r_xmaj) begin
            px = r_x0 + r_step;
            py = r_fall ? (r_y0 - minor_ceil) : (r_y0 + quo_nxt);
        end else begin
            px = r_x0 + quo_nxt;
            py = r_fall ? (r_y0 - r_step) : (r_y0 + r_step);
        end
    end

    always_comb begin
        o_sts.empty = (r_dmaj[COORD_BITS-1:1] == '0);
        o_sts.last  = (r_step == (r_dmaj - t_coord'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0   <= x0;
            r_y0   <= y0;
            r_fall <= fall;
            r_xmaj <= xmaj;
            r_dmaj <= xmaj ? dx : dy;
            r_dmin <= xmaj ? dy : dx;
            r_step <= t_coord'(1);
            r_quo  <= '0;
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_step <= r_step + t_coord'(1);
            r_quo  <= quo_nxt;
            r_rem  <= rem_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_px   <= px;
            r_py   <= py;
            r_last <= o_sts.last;
        end
    end

    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_last;

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import lerast_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   last_pix;
    } t_pixel;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;   // start_x, start_y, end_x, end_y
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // pixel_x, pixel_y, zero pad
    logic                      m_axis_tlast;   // last_pixel

    t_pixel pixel_q[$];
    int     error_count = 0;
    bit     tx_idle_en = 1'b1;
    bit     rx_idle_en = 1'b1;
    int     rx_hold_req = 0;

    line_equation_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Expected interior pixels of one line, in order of the major axis.
    function automatic void plot_line(t_coord ax, t_coord ay, t_coord bx, t_coord by);
        int     x0, y0, x1, y1, dx, dy, n, py, px;
        bit     fall;
        t_pixel pix;
        if (bx < ax) begin
            x0 = bx; y0 = by; x1 = ax; y1 = ay;
        end else begin
            x0 = ax; y0 = ay; x1 = bx; y1 = by;
        end
        fall = (y1 < y0);
        dx = x1 - x0;
        dy = fall ? (y0 - y1) : (y1 - y0);
        if (dy < dx) begin
            n = dx - 1;
            for (int s = 1; s <= n; s++) begin
                // falling: adding dx - 1 before the division rounds the step up
                py = fall ? y0 - (dy * s + dx - 1) / dx : y0 + (dy * s) / dx;
                pix.px = t_coord'(x0 + s);
                pix.py = t_coord'(py);
                pix.last_pix = (s == n);
                pixel_q.push_back(pix);
            end
        end else if (dy != 0) begin
            n = dy - 1;
            for (int s = 1; s <= n; s++) begin
                px = x0 + (dx * s) / dy;
                pix.px = t_coord'(px);
                pix.py = t_coord'(fall ? y0 - s : y0 + s);
                pix.last_pix = (s == n);
                pixel_q.push_back(pix);
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        error_count++;
    endtask

    task automatic send_line(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 25) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'({ey, ex, sy, sx});
        do @(posedge i_clk); while (!s_axis_tready);
        plot_line(sx, sy, ex, ey);
    endtask

    // Sender stops offering until every pixel owed has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_line(0, 0, 0, 0);        // coinciding
        send_line(5, 5, 6, 6);        // adjacent, diagonal
        send_line(0, 0, 1, 0);        // adjacent, horizontal
        send_line(20, 21, 20, 20);    // adjacent, vertical
        send_line(63, 63, 62, 62);
        send_line(0, 0, 63, 63);      // longest diagonal
        send_line(63, 63, 0, 0);
        send_line(0, 63, 63, 0);      // falling diagonal
        send_line(63, 0, 0, 63);
        send_line(0, 0, 63, 0);
        send_line(63, 0, 0, 0);
        send_line(0, 0, 0, 63);
        send_line(0, 63, 0, 0);
        send_line(7, 40, 7, 3);
        send_line(0, 0, 63, 1);       // shallow rising
        send_line(0, 1, 63, 0);       // shallow falling
        send_line(0, 0, 1, 63);       // steep rising
        send_line(1, 63, 0, 0);       // steep, endpoints swapped
        send_line(10, 20, 40, 31);
        send_line(40, 31, 10, 20);
        send_line(3, 50, 60, 7);
        send_line(42, 21, 21, 42);
        wait_drained();
    endtask

    task automatic test_random(int count);
        t_coord sx, sy, ex, ey;
        int     kind;
        for (int i = 0; i < count; i++) begin
            sx = t_coord'($urandom);
            sy = t_coord'($urandom);
            ex = t_coord'($urandom);
            ey = t_coord'($urandom);
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    // degenerate: coinciding or adjacent endpoints, unless a coordinate wraps
                    ex = t_coord'(sx + $urandom_range(0, 1));
                    ey = t_coord'(sy + $urandom_range(0, 1));
                end
                1: ex = sx;
                2: ey = sy;
                3: begin
                    ex = t_coord'(sx + 7);
                    ey = $urandom_range(0, 1) ? t_coord'(sy + 7) : t_coord'(sy - 7);
                end
                4, 5: begin
                    ex = t_coord'(sx + $urandom_range(0, 8) - 4);
                    ey = t_coord'(sy + $urandom_range(0, 8) - 4);
                end
                default: ;
            endcase
            send_line(sx, sy, ex, ey);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold_req = 300;
        send_line(0, 0, 63, 40);
        send_line(63, 5, 2, 60);
        send_line(30, 0, 33, 63);
        send_line(0, 62, 62, 1);
        wait_drained();
    endtask

    task automatic test_full_rate(int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_line(t_coord'($urandom), t_coord'($urandom),
                      t_coord'($urandom), t_coord'($urandom));
        end
        wait_drained();
    endtask

    // Receiver: random stall bursts, plus a long hold when asked for.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                stall_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel exp_pix;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected transaction, pixel_x", m_axis_tdata[5:0], -1);
            end else begin
                exp_pix = pixel_q.pop_front();
                if (m_axis_tdata[COORD_BITS-1:0] !== exp_pix.px)
                    report_mismatch("pixel_x", m_axis_tdata[COORD_BITS-1:0], exp_pix.px);
                if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== exp_pix.py)
                    report_mismatch("pixel_y", m_axis_tdata[2*COORD_BITS-1:COORD_BITS],
                                    exp_pix.py);
                if (m_axis_tlast !== exp_pix.last_pix)
                    report_mismatch("last_pixel", m_axis_tlast, exp_pix.last_pix);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(54);
        test_backpressure();
        test_full_rate(20);

        repeat (70) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
